// File: sv/dssr_pkg.sv
// Shared types, constants and a helper function for the binary64 scale/split/round unit.
`default_nettype none
package dssr_pkg;

    typedef enum logic [2:0] {
        ACT_SPLIT = 3'd0,
        ACT_SCALE = 3'd1,
        ACT_PART  = 3'd2,
        ACT_FLOOR = 3'd3,
        ACT_CEIL  = 3'd4,
        ACT_ROUND = 3'd5
    } action_t;

    localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;
    localparam logic [10:0] EXP_HALF     = 11'h3FE;
    localparam logic [10:0] EXP_ONE      = 11'h3FF;
    localparam logic [51:0] MANT_ONES    = {52{1'b1}};

    // Index of the leading one of a 52-bit field; zero for an empty field.
    function automatic logic [5:0] lead_one(input logic [51:0] v);
        logic [5:0] idx;
        idx = 6'd0;
        for (int i = 0; i < 52; i++) begin
            if (v[i])
            begin
                idx = 6'(i);
            end
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

// File: sv/double_scale_split_round_unit.sv
// Top level of the binary64 scale, split, part-split and rounding unit.
//
// Usage: one request channel (in_valid / in_stall) carries action, value_bits
// and scale_exp; one result channel (out_valid / out_stall) carries
// result_bits, int_part_bits, exponent_out, is_nan and is_inf.
// A request is taken on a rising edge with valid high and stall low.
// The request passes through three register stages: out_valid rises when it
// reaches the stage 3 register, and the result leaves on an edge with out_stall low.
// One request per cycle unless in_stall holds it, over three register stages:
//   stage 1: decode, leading-one search over the operand mantissa, masks
//   stage 2: normalise split mantissa, leading-one search over the fraction,
//            integer increment for floor / ceiling / round
//   stage 3: scale exponent add and underflow shift, fraction normalise, mux
// Reset clears the stage valid bits only; payload registers hold garbage.
// When the receiver stalls, the result holds on the outputs and stages fill
// behind it; empty stages keep advancing so bubbles are squeezed out.
// in_stall rises only when all three stages hold requests and the output
// is stalled. No configuration, no state across requests.
`default_nettype none
module double_scale_split_round_unit
    import dssr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_stall,
    input  wire logic [2:0]         action,
    input  wire logic [63:0]        value_bits,
    input  wire logic signed [12:0] scale_exp,
    output      logic               out_valid,
    input  wire logic               out_stall,
    output      logic [63:0]        result_bits,
    output      logic [63:0]        int_part_bits,
    output      logic signed [11:0] exponent_out,
    output      logic               is_nan,
    output      logic               is_inf
);

    // Stage advance: a stage loads when it is empty or its content moves on.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic adv1, adv2, adv3;

    assign adv3     = !s3_valid_reg || !out_stall;
    assign adv2     = adv3 || !s2_valid_reg;
    assign adv1     = adv2 || !s1_valid_reg;
    assign in_stall = !adv1;

    // ---------------- stage 1: decode ----------------
    logic [10:0] a_raw;
    logic [51:0] a_mant;
    logic [11:0] a_e;
    logic        a_eneg, a_big;
    logic [51:0] a_fmask;

    logic [2:0]         s1_act_next;
    logic [63:0]        s1_vb_next;
    logic signed [12:0] s1_k_next;
    logic [5:0]         s1_p_next, s1_e6_next;
    logic [51:0]        s1_fbits_next, s1_ipmant_next;
    logic               s1_eneg_next, s1_big_next, s1_half_next;

    logic [2:0]         s1_act_reg;
    logic [63:0]        s1_vb_reg;
    logic signed [12:0] s1_k_reg;
    logic [5:0]         s1_p_reg, s1_e6_reg;
    logic [51:0]        s1_fbits_reg, s1_ipmant_reg;
    logic               s1_eneg_reg, s1_big_reg, s1_half_reg;

    always_comb
    begin
        a_raw   = value_bits[62:52];
        a_mant  = value_bits[51:0];
        a_e     = {1'b0, a_raw} - 12'd1023;
        a_eneg  = a_raw < 11'd1023;
        a_big   = a_raw >= 11'd1075;
        a_fmask = (a_eneg || a_big) ? 52'd0 : (MANT_ONES >> a_e[5:0]);

        s1_act_next    = action;
        s1_vb_next     = value_bits;
        // saturate the bottom code
        s1_k_next      = (scale_exp == -13'sd4096) ? -13'sd4095 : scale_exp;
        s1_p_next      = lead_one(a_mant);
        s1_e6_next     = a_e[5:0];
        s1_fbits_next  = a_mant & a_fmask;
        s1_ipmant_next = a_mant & ~a_fmask;
        s1_eneg_next   = a_eneg;
        s1_big_next    = a_big;
        // half bit: first fraction place, or magnitude at least one half
        s1_half_next   = a_eneg ? (a_raw >= EXP_HALF)
                                : ((a_mant & a_fmask & ~(a_fmask >> 1)) != 52'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv1)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_act_reg    <= s1_act_next;
            s1_vb_reg     <= s1_vb_next;
            s1_k_reg      <= s1_k_next;
            s1_p_reg      <= s1_p_next;
            s1_e6_reg     <= s1_e6_next;
            s1_fbits_reg  <= s1_fbits_next;
            s1_ipmant_reg <= s1_ipmant_next;
            s1_eneg_reg   <= s1_eneg_next;
            s1_big_reg    <= s1_big_next;
            s1_half_reg   <= s1_half_next;
        end
    end

    // ---------------- stage 2: normalise, increment ----------------
    logic        b_sign, b_zero, b_special, b_sub, b_fnz, b_incr;
    logic [10:0] b_raw;
    logic [51:0] b_mant;
    logic [12:0] b_ex13;
    logic [62:0] b_incmag;
    logic [63:0] b_ipv;

    logic [2:0]         s2_act_next;
    logic [63:0]        s2_vb_next, s2_ipv_next, s2_rnd_next;
    logic signed [12:0] s2_k_next;
    logic [51:0]        s2_nfrac_next, s2_fbits_next;
    logic signed [11:0] s2_nex_next;
    logic [5:0]         s2_q_next, s2_e6_next;
    logic               s2_fnz_next, s2_eneg_next, s2_big_next;

    logic [2:0]         s2_act_reg;
    logic [63:0]        s2_vb_reg, s2_ipv_reg, s2_rnd_reg;
    logic signed [12:0] s2_k_reg;
    logic [51:0]        s2_nfrac_reg, s2_fbits_reg;
    logic signed [11:0] s2_nex_reg;
    logic [5:0]         s2_q_reg, s2_e6_reg;
    logic               s2_fnz_reg, s2_eneg_reg, s2_big_reg;

    always_comb
    begin
        b_sign    = s1_vb_reg[63];
        b_raw     = s1_vb_reg[62:52];
        b_mant    = s1_vb_reg[51:0];
        b_zero    = (s1_vb_reg[62:0] == 63'd0);
        b_special = (b_raw == EXP_ALL_ONES);
        b_sub     = (b_raw == 11'd0);
        b_ex13    = b_sub ? (13'(s1_p_reg) - 13'd1073) : (13'(b_raw) - 13'd1022);

        // integer part as a part split sees it
        if (s1_eneg_reg)
        begin
            b_ipv = {b_sign, 63'd0};
        end
        else if (s1_big_reg)
        begin
            b_ipv = s1_vb_reg;
        end
        else
        begin
            b_ipv = {b_sign, b_raw, s1_ipmant_reg};
        end

        b_fnz    = s1_eneg_reg ? !b_zero : (s1_fbits_reg != 52'd0);
        // truncated magnitude plus one; a carry out of the mantissa lifts the exponent
        b_incmag = s1_eneg_reg ? {EXP_ONE, 52'd0}
                               : ({b_raw, s1_ipmant_reg}
                                  + (63'd1 << (6'd52 - s1_e6_reg)));

        case (s1_act_reg)
            ACT_FLOOR: b_incr = b_fnz && b_sign;
            ACT_CEIL:  b_incr = b_fnz && !b_sign;
            ACT_ROUND: b_incr = s1_half_reg && !s1_big_reg;
            default:   b_incr = 1'b0;
        endcase

        s2_act_next   = s1_act_reg;
        s2_vb_next    = s1_vb_reg;
        s2_k_next     = s1_k_reg;
        s2_ipv_next   = b_ipv;
        s2_rnd_next   = b_special ? s1_vb_reg
                      : (b_incr ? {b_sign, b_incmag} : b_ipv);
        s2_nfrac_next = b_sub ? (b_mant << (6'd52 - s1_p_reg)) : b_mant;
        s2_nex_next   = b_ex13[11:0];
        s2_fbits_next = s1_fbits_reg;
        s2_q_next     = lead_one(s1_fbits_reg);
        s2_e6_next    = s1_e6_reg;
        s2_fnz_next   = b_fnz;
        s2_eneg_next  = s1_eneg_reg;
        s2_big_next   = s1_big_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv2)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            s2_act_reg   <= s2_act_next;
            s2_vb_reg    <= s2_vb_next;
            s2_k_reg     <= s2_k_next;
            s2_ipv_reg   <= s2_ipv_next;
            s2_rnd_reg   <= s2_rnd_next;
            s2_nfrac_reg <= s2_nfrac_next;
            s2_nex_reg   <= s2_nex_next;
            s2_fbits_reg <= s2_fbits_next;
            s2_q_reg     <= s2_q_next;
            s2_e6_reg    <= s2_e6_next;
            s2_fnz_reg   <= s2_fnz_next;
            s2_eneg_reg  <= s2_eneg_next;
            s2_big_reg   <= s2_big_next;
        end
    end

    // ---------------- stage 3: scale, fraction, select ----------------
    logic        c_sign, c_zero, c_special, c_nan, c_inf;
    logic [13:0] c_biased, c_sh;
    logic [52:0] c_sig;
    logic [63:0] c_scale, c_frac, c_part, c_split;
    logic [51:0] c_ffrac;
    logic [10:0] c_fexp;

    logic [63:0]        res_next, ip_next;
    logic signed [11:0] ex_next;
    logic               nan_next, inf_next;

    logic [63:0]        res_reg, ip_reg;
    logic signed [11:0] ex_reg;
    logic               nan_reg, inf_reg;

    always_comb
    begin
        c_sign    = s2_vb_reg[63];
        c_zero    = (s2_vb_reg[62:0] == 63'd0);
        c_special = (s2_vb_reg[62:52] == EXP_ALL_ONES);
        c_nan     = c_special && (s2_vb_reg[51:0] != 52'd0);
        c_inf     = c_special && (s2_vb_reg[51:0] == 52'd0);

        // scale by a power of two
        c_biased = {{2{s2_nex_reg[11]}}, s2_nex_reg} + {s2_k_reg[12], s2_k_reg}
                 + 14'd1022;
        c_sh     = 14'd1 - c_biased;
        c_sig    = {1'b1, s2_nfrac_reg};
        if (c_zero)
        begin
            c_scale = 64'd0;
        end
        else if (c_special)
        begin
            c_scale = s2_vb_reg;
        end
        else if (!c_biased[13] && c_biased >= 14'd2047)
        begin
            c_scale = {c_sign, EXP_ALL_ONES, 52'd0};
        end
        else if (c_biased[13] || c_biased == 14'd0)
        begin
            // underflow: truncate, drop everything past 53 places
            if (c_sh > 14'd53)
            begin
                c_scale = {c_sign, 63'd0};
            end
            else
            begin
                c_scale = {c_sign, 10'd0, c_sig >> c_sh[5:0]};
            end
        end
        else
        begin
            c_scale = {c_sign, c_biased[10:0], s2_nfrac_reg};
        end

        // exact fraction of a part split
        c_ffrac = s2_fbits_reg << (6'd52 - s2_q_reg);
        c_fexp  = 11'(s2_q_reg) + 11'(s2_e6_reg) + 11'd971;
        c_frac  = {c_sign, c_fexp, c_ffrac};
        if (c_nan)
        begin
            c_part = s2_vb_reg;
        end
        else if (c_zero || c_inf || s2_big_reg)
        begin
            c_part = 64'd0;
        end
        else if (s2_eneg_reg)
        begin
            c_part = s2_vb_reg;
        end
        else
        begin
            c_part = s2_fnz_reg ? c_frac : 64'd0;
        end

        c_split = c_zero ? 64'd0
                : (c_special ? s2_vb_reg : {c_sign, EXP_HALF, s2_nfrac_reg});

        res_next = 64'd0;
        ip_next  = 64'd0;
        ex_next  = 12'sd0;
        case (s2_act_reg)
            ACT_SPLIT:
            begin
                res_next = c_split;
                ex_next  = (c_zero || c_special) ? 12'sd0 : s2_nex_reg;
            end
            ACT_SCALE: res_next = c_scale;
            ACT_PART:
            begin
                res_next = c_part;
                ip_next  = s2_ipv_reg;
            end
            ACT_FLOOR, ACT_CEIL, ACT_ROUND: res_next = s2_rnd_reg;
            default: res_next = 64'd0;
        endcase
        nan_next = c_nan;
        inf_next = c_inf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (adv3)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            res_reg <= res_next;
            ip_reg  <= ip_next;
            ex_reg  <= ex_next;
            nan_reg <= nan_next;
            inf_reg <= inf_next;
        end
    end

    assign out_valid     = s3_valid_reg;
    assign result_bits   = res_reg;
    assign int_part_bits = ip_reg;
    assign exponent_out  = ex_reg;
    assign is_nan        = nan_reg;
    assign is_inf        = inf_reg;

endmodule
`default_nettype wire

// File: sim/double_scale_split_round_unit_chk.sv
// Checker for the binary64 scale/split/round unit: predicts each request and compares results.
module double_scale_split_round_unit_chk
    import dssr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [2:0]         action,
    input  logic [63:0]        value_bits,
    input  logic signed [12:0] scale_exp,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [63:0]        result_bits,
    input  logic [63:0]        int_part_bits,
    input  logic signed [11:0] exponent_out,
    input  logic               is_nan,
    input  logic               is_inf,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic [63:0]        res;
        logic [63:0]        ipart;
        logic signed [11:0] ex;
        logic               nan;
        logic               inf;
    } dbl_result_t;

    dbl_result_t result_queue[$];

    function automatic logic is_zero_b(input logic [63:0] b);
        return b[62:0] == 63'd0;
    endfunction

    function automatic logic is_spec_b(input logic [63:0] b);
        return b[62:52] == EXP_ALL_ONES;
    endfunction

    function automatic logic [63:0] split_dbl(input logic [63:0] b, output int ex);
        logic [63:0] v;
        int adj;
        ex = 0;
        adj = 0;
        v = b;
        if (is_zero_b(b)) return 64'd0;
        if (is_spec_b(b)) return b;
        if (v[62:52] == 11'd0)
        begin
            v = $realtobits($bitstoreal(v) * 18014398509481984.0);
            adj = -54;
        end
        ex = int'(v[62:52]) - 1022 + adj;
        return {v[63], EXP_HALF, v[51:0]};
    endfunction

    function automatic logic [63:0] scale_dbl(input logic [63:0] b, input int k);
        logic [63:0] m;
        logic [52:0] full;
        int ex;
        int biased;
        int sh;
        if (is_zero_b(b)) return 64'd0;
        if (is_spec_b(b)) return b;
        m = split_dbl(b, ex);
        biased = ex + k + 1022;
        if (biased >= 2047) return {b[63], EXP_ALL_ONES, 52'd0};
        if (biased <= 0)
        begin
            sh = 1 - biased;
            if (sh > 53) return {b[63], 63'd0};
            full = {1'b1, m[51:0]} >> sh;
            return {b[63], 10'd0, full};
        end
        return {b[63], biased[10:0], m[51:0]};
    endfunction

    function automatic logic [63:0] part_dbl(input logic [63:0] b, output logic [63:0] ip);
        logic [63:0] fr;
        int e;
        ip = b;
        if (is_spec_b(b) && b[51:0] != 52'd0) return b;
        if (is_spec_b(b) || is_zero_b(b)) return 64'd0;
        e = int'(b[62:52]) - 1023;
        if (e < 0)
        begin
            ip = {b[63], 63'd0};
            return b;
        end
        if (e >= 52) return 64'd0;
        ip = b & (~64'd0 << (52 - e));
        fr = $realtobits($bitstoreal(b) - $bitstoreal(ip));
        return is_zero_b(fr) ? 64'd0 : fr;
    endfunction

    function automatic logic [63:0] round_dbl(input logic [63:0] b, input logic [2:0] act);
        logic [63:0] ip;
        logic [63:0] fr;
        real x;
        real f;
        real i;
        if (is_spec_b(b)) return b;
        fr = part_dbl(b, ip);
        x = $bitstoreal(b);
        f = $bitstoreal(fr);
        i = $bitstoreal(ip);
        if (act == ACT_FLOOR) return (f < 0.0) ? $realtobits(i - 1.0) : ip;
        if (act == ACT_CEIL) return (f > 0.0) ? $realtobits(i + 1.0) : ip;
        if (((f < 0.0) ? -f : f) >= 0.5)
            return $realtobits((x > 0.0) ? i + 1.0 : i - 1.0);
        return ip;
    endfunction

    function automatic dbl_result_t predict_dbl(input logic [2:0] act, input logic [63:0] v,
                                                input logic signed [12:0] se);
        dbl_result_t r;
        int k;
        int ex;
        logic [63:0] ip;
        k = int'(se);
        if (k < -4095) k = -4095;
        ex = 0;
        ip = 64'd0;
        r.res = 64'd0;
        case (act)
            ACT_SPLIT: r.res = split_dbl(v, ex);
            ACT_SCALE: r.res = scale_dbl(v, k);
            ACT_PART:  r.res = part_dbl(v, ip);
            ACT_FLOOR, ACT_CEIL, ACT_ROUND: r.res = round_dbl(v, act);
            default: r.res = 64'd0;
        endcase
        r.ipart = ip;
        r.ex = ex[11:0];
        r.nan = is_spec_b(v) && v[51:0] != 52'd0;
        r.inf = is_spec_b(v) && v[51:0] == 52'd0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        dbl_result_t w;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                result_queue.push_back(predict_dbl(action, value_bits, scale_exp));
            if (out_valid && !out_stall)
            begin
                if (result_queue.size() == 0)
                    report_mismatch("unexpected result", result_bits, 64'd0);
                else
                begin
                    w = result_queue.pop_front();
                    if (result_bits !== w.res)
                        report_mismatch("result_bits", result_bits, w.res);
                    if (int_part_bits !== w.ipart)
                        report_mismatch("int_part_bits", int_part_bits, w.ipart);
                    if (exponent_out !== w.ex)
                        report_mismatch("exponent_out", 64'(exponent_out), 64'(w.ex));
                    if (is_nan !== w.nan)
                        report_mismatch("is_nan", 64'(is_nan), 64'(w.nan));
                    if (is_inf !== w.inf)
                        report_mismatch("is_inf", 64'(is_inf), 64'(w.inf));
                end
            end
            pending <= result_queue.size();
        end
    end

endmodule

// File: sim/double_scale_split_round_unit_tb.sv
// Testbench top for the binary64 scale/split/round unit: stimulus, stalls and verdict.
module double_scale_split_round_unit_tb
    import dssr_pkg::*;
;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         action;
    logic [63:0]        value_bits;
    logic signed [12:0] scale_exp;
    logic               out_valid;
    logic               out_stall;
    logic [63:0]        result_bits;
    logic [63:0]        int_part_bits;
    logic signed [11:0] exponent_out;
    logic               is_nan;
    logic               is_inf;
    int                 fail_count;
    int                 pending;
    // When set, neither side idles: run back-to-back bursts
    logic               no_idle;

    double_scale_split_round_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .value_bits(value_bits), .scale_exp(scale_exp),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_bits(result_bits), .int_part_bits(int_part_bits),
        .exponent_out(exponent_out), .is_nan(is_nan), .is_inf(is_inf)
    );

    double_scale_split_round_unit_chk i_chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .value_bits(value_bits), .scale_exp(scale_exp),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_bits(result_bits), .int_part_bits(int_part_bits),
        .exponent_out(exponent_out), .is_nan(is_nan), .is_inf(is_inf),
        .fail_count(fail_count), .pending(pending)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Drive every input to a known value from time zero
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = 3'd0;
        value_bits = 64'd0;
        scale_exp = 13'sd0;
        out_stall = 1'b0;
        no_idle = 1'b0;
    end

    // Receiver side: after each accepted result draw a fresh stall length.
    // Sampling right after the edge sees the values from before it.
    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                hold = no_idle ? 0 : $urandom_range(0, 5);
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                hold--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Hand one request to the block. Idle first for a drawn number of cycles;
    // with no gap keep valid high so it never drops and rises in one step.
    task automatic send_request(input logic [2:0] act, input logic [63:0] v,
                                input logic signed [12:0] se);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        action <= act;
        value_bits <= v;
        scale_exp <= se;
        in_valid <= 1'b1;
        // Hold the request until an edge sees it accepted
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Operand mix: values whose integer/fraction boundary is in range, very small and
    // very large exponents, plus zeros, subnormals, specials and fully random patterns.
    function automatic logic [63:0] draw_operand();
        logic [10:0] e;
        logic [51:0] m;
        case ($urandom_range(0, 9))
            0: e = 11'd0;
            1: e = EXP_ALL_ONES;
            2: e = 11'($urandom_range(1, 60));
            3: e = 11'($urandom_range(1990, 2046));
            4, 5, 6: e = 11'($urandom_range(1010, 1080));
            default: e = 11'($urandom_range(0, 2047));
        endcase
        case ($urandom_range(0, 5))
            0: m = 52'd0;
            1: m = 52'd1 << $urandom_range(0, 51);
            2: m = MANT_ONES;
            3: m = MANT_ONES << $urandom_range(0, 51);
            default: m = 52'({$urandom(), $urandom()});
        endcase
        return {1'($urandom_range(0, 1)), e, m};
    endfunction

    function automatic logic signed [12:0] draw_scale();
        case ($urandom_range(0, 5))
            0: return -13'sd4096;
            1: return 13'sd4095;
            2: return 13'($urandom_range(0, 8191));
            default: return 13'($signed($urandom_range(0, 2400)) - 1200);
        endcase
    endfunction

    initial
    begin
        logic [2:0] act;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zeros, subnormals, extremes, specials, ordinary values and unused action codes
        send_request(ACT_SPLIT, 64'h8000000000000000, 13'sd0);
        send_request(ACT_SPLIT, 64'h0000000000000001, 13'sd0);
        send_request(ACT_SPLIT, 64'h7FEFFFFFFFFFFFFF, 13'sd0);
        send_request(ACT_SPLIT, 64'h7FF8000000000001, 13'sd0);
        send_request(ACT_SPLIT, 64'hFFF0000000000000, 13'sd0);
        send_request(ACT_SCALE, 64'h8000000000000000, 13'sd5);
        send_request(ACT_SCALE, 64'h3FF0000000000000, 13'sd4095);
        send_request(ACT_SCALE, 64'hBFF0000000000000, -13'sd4096);
        send_request(ACT_SCALE, 64'h3FFFFFFFFFFFFFFF, -13'sd1030);
        send_request(ACT_SCALE, 64'hBFF8000000000000, -13'sd1075);
        send_request(ACT_SCALE, 64'h000FFFFFFFFFFFFF, 13'sd1);
        send_request(ACT_PART,  64'h7FF0000000000001, 13'sd0);
        send_request(ACT_PART,  64'hFFF0000000000000, 13'sd0);
        send_request(ACT_PART,  64'hBFE0000000000000, 13'sd0);
        send_request(ACT_PART,  64'h4004000000000000, 13'sd0);
        send_request(ACT_PART,  64'h4330000000000001, 13'sd0);
        send_request(ACT_PART,  64'h8000000000000000, 13'sd0);
        send_request(ACT_FLOOR, 64'hBFF8000000000000, 13'sd0);
        send_request(ACT_CEIL,  64'h3FF8000000000000, 13'sd0);
        send_request(ACT_ROUND, 64'h4004000000000000, 13'sd0);
        send_request(ACT_ROUND, 64'hC004000000000000, 13'sd0);
        send_request(ACT_ROUND, 64'h3FDFFFFFFFFFFFFF, 13'sd0);
        send_request(3'd6, 64'h7FF8000000000000, 13'sd7);
        send_request(3'd7, 64'hFFF0000000000000, -13'sd1);

        // Random: every action code, bursts with no idling every so often
        for (int n = 0; n < 1450; n++)
        begin
            if (n % 200 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            act = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                : 3'($urandom_range(0, 5));
            send_request(act, draw_operand(), draw_scale());
        end
        in_valid <= 1'b0;

        // Drain: wait for every result, then keep the clock running for strays
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
